>>> hw/rtl/ihcrc_pkg.sv
// shared types, status codes and crc helper for the hex record crc unit
package ihcrc_pkg;

   // line status codes
   localparam logic [3:0] ST_OK             = 4'd0;
   localparam logic [3:0] ST_BAD_SUM        = 4'd1;
   localparam logic [3:0] ST_SUM_UNREADABLE = 4'd2;
   localparam logic [3:0] ST_BLANK          = 4'd3;
   localparam logic [3:0] ST_NO_COLON       = 4'd4;
   localparam logic [3:0] ST_BAD_LEN        = 4'd5;
   localparam logic [3:0] ST_BAD_OFFSET     = 4'd6;
   localparam logic [3:0] ST_BAD_TYPE       = 4'd7;
   localparam logic [3:0] ST_OTHER_TYPE     = 4'd8;
   localparam logic [3:0] ST_ZERO_LEN       = 4'd9;
   localparam logic [3:0] ST_FATAL_DIGIT    = 4'd10;
   localparam logic [3:0] ST_FATAL_OVERLONG = 4'd11;

   // result kinds
   localparam logic KIND_LINE  = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // input word types
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // special characters
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // reflected crc-32
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // classified input word
   typedef struct packed {
      logic       is_end;
      logic       is_newline;
      logic       is_colon;
      logic       is_cr;
      logic       is_hex;
      logic [3:0] nibble;
   } item_type;

   // one byte through the crc, lsb first
   function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] data);
      logic [31:0] r;
      r = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/ihcrc_front.sv
// front stage: accepts character and end words and classifies them into items
module ihcrc_front import ihcrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_char_in,
   output logic       push,
   output item_type   push_item,
   input  logic       queue_full
);

   logic     front_valid_ff;
   logic     front_valid_in;
   item_type front_item_ff;
   item_type class_item;

   // classify the incoming word
   always_comb begin
      class_item            = '0;
      class_item.is_end     = (req_type == REQ_END);
      if (req_type == REQ_CHAR) begin
         class_item.is_newline = (req_char_in == CHAR_NEWLINE);
         class_item.is_colon   = (req_char_in == CHAR_COLON);
         class_item.is_cr      = (req_char_in == CHAR_CR);
         if (req_char_in >= 8'h30 && req_char_in <= 8'h39) begin
            class_item.is_hex = 1'b1;
            class_item.nibble = 4'(req_char_in - 8'h30);
         end else if (req_char_in >= 8'h61 && req_char_in <= 8'h66) begin
            class_item.is_hex = 1'b1;
            class_item.nibble = 4'(req_char_in - 8'h57);
         end else if (req_char_in >= 8'h41 && req_char_in <= 8'h46) begin
            class_item.is_hex = 1'b1;
            class_item.nibble = 4'(req_char_in - 8'h37);
         end
      end
   end

   // stall only while the stage holds a word the queue cannot take
   assign req_stall = front_valid_ff && queue_full;
   assign push      = front_valid_ff && !queue_full;
   assign push_item = front_item_ff;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (!req_stall) begin
         front_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         front_item_ff <= class_item;
      end
   end

endmodule

>>> hw/rtl/ihcrc_queue.sv
// small fifo of classified items between front and back
module ihcrc_queue import ihcrc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     empty,
   output logic     full
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign head_item = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/ihcrc_back.sv
// back end: record parser, crc update and result register
module ihcrc_back import ihcrc_pkg::*; #(
   parameter int MAX_LINE = 1023
) (
   input  logic        clock,
   input  logic        reset,
   input  item_type    head_item,
   input  logic        queue_empty,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_line_status,
   output logic [31:0] rsp_line_number,
   output logic [7:0]  rsp_record_type,
   output logic [31:0] rsp_crc_value,
   output logic        rsp_aborted
);

   localparam int PW = $clog2(MAX_LINE);
   localparam int KW = (PW > 9) ? PW + 1 : 10;
   localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE - 1);

   // parser state
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   lines_ff, lines_in;
   logic [31:0]   crc_ff, crc_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    sum_ff, sum_in;
   logic [3:0]    nib_ff, nib_in;
   logic [3:0]    outcome_ff, outcome_in;
   logic          fatal_ff, fatal_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          kind_ff;
   logic [3:0]    status_ff;
   logic [31:0]   number_ff;
   logic [7:0]    rtype_ff;
   logic [31:0]   rcrc_ff;
   logic          abort_ff;

   // result produced this cycle
   logic          res_valid;
   logic          res_kind;
   logic [3:0]    res_status;
   logic [31:0]   res_number;
   logic [7:0]    res_rtype;
   logic [31:0]   res_crc;
   logic          res_abort;

   logic          go;
   logic          out_free;
   logic [3:0]    fail_s;
   logic [7:0]    byte_val;
   logic [7:0]    sum_next;
   logic [KW-1:0] byte_idx;
   logic [KW-1:0] data_lim;
   logic [PW-1:0] pos_m1;

   // status of a line whose byte at the current position cannot be read
   function automatic logic [3:0] fail_status(logic [KW-1:0] k, logic [KW-1:0] lim);
      logic [3:0] s;
      if (k == '0) begin
         s = ST_BAD_LEN;
      end else if (k <= KW'(2)) begin
         s = ST_BAD_OFFSET;
      end else if (k == KW'(3)) begin
         s = ST_BAD_TYPE;
      end else if (k < lim) begin
         s = ST_FATAL_DIGIT;
      end else begin
         s = ST_SUM_UNREADABLE;
      end
      return s;
   endfunction

   // byte index within the record and end of data
   assign pos_m1   = pos_ff - PW'(1);
   assign byte_idx = KW'(pos_m1[PW-1:1]);
   assign data_lim = KW'(len_ff) + KW'(4);
   assign fail_s   = fail_status(byte_idx, data_lim);
   assign byte_val = {nib_ff, head_item.nibble};
   assign sum_next = sum_ff + byte_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = !queue_empty && out_free;

   // item execution
   always_comb begin
      pos_in     = pos_ff;
      lines_in   = lines_ff;
      crc_in     = crc_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      sum_in     = sum_ff;
      nib_in     = nib_ff;
      outcome_in = outcome_ff;
      fatal_in   = fatal_ff;
      pop        = 1'b0;
      res_valid  = 1'b0;
      res_kind   = KIND_LINE;
      res_status = ST_OK;
      res_number = lines_ff;
      res_rtype  = type_ff;
      res_crc    = crc_ff;
      res_abort  = 1'b0;
      if (go) begin
         pop = 1'b1;
         if (head_item.is_end) begin
            res_valid = 1'b1;
            if (!fatal_ff && pos_ff != '0) begin
               // close the open line first; the end word stays queued and the final report follows
               pop = 1'b0;
               if (outcome_ff == 4'd0) begin
                  res_status = fail_s;
                  if (fail_s == ST_FATAL_DIGIT) begin
                     fatal_in  = 1'b1;
                     res_abort = 1'b1;
                  end else begin
                     pos_in = '0;
                  end
               end else begin
                  res_status = outcome_ff - 4'd1;
                  pos_in     = '0;
                  outcome_in = 4'd0;
               end
            end else begin
               // final report, then back to the reset state
               res_kind   = KIND_FINAL;
               res_rtype  = 8'd0;
               res_crc    = ~crc_ff;
               res_abort  = fatal_ff;
               pos_in     = '0;
               lines_in   = 32'd0;
               crc_in     = CRC_PRESET;
               len_in     = 8'd0;
               type_in    = 8'd0;
               sum_in     = 8'd0;
               nib_in     = 4'd0;
               outcome_in = 4'd0;
               fatal_in   = 1'b0;
            end
         end else if (fatal_ff) begin
            // characters after a fatal error are dropped
         end else if (head_item.is_newline) begin
            res_valid = 1'b1;
            if (pos_ff == '0) begin
               lines_in   = lines_ff + 32'd1;
               type_in    = 8'd0;
               res_status = ST_BLANK;
               res_number = lines_ff + 32'd1;
               res_rtype  = 8'd0;
            end else if (outcome_ff == 4'd0) begin
               res_status = fail_s;
               if (fail_s == ST_FATAL_DIGIT) begin
                  fatal_in  = 1'b1;
                  res_abort = 1'b1;
               end else begin
                  pos_in = '0;
               end
            end else begin
               res_status = outcome_ff - 4'd1;
               pos_in     = '0;
               outcome_in = 4'd0;
            end
         end else if (pos_ff == '0) begin
            // first character of a line
            lines_in = lines_ff + 32'd1;
            len_in   = 8'd0;
            type_in  = 8'd0;
            sum_in   = 8'd0;
            nib_in   = 4'd0;
            pos_in   = PW'(1);
            if (head_item.is_colon) begin
               outcome_in = 4'd0;
            end else if (head_item.is_cr) begin
               outcome_in = ST_BLANK + 4'd1;
            end else begin
               outcome_in = ST_NO_COLON + 4'd1;
            end
         end else if (outcome_ff == ST_BLANK + 4'd1) begin
            // rest of a blank line is ignored
         end else if (pos_ff >= POS_LAST) begin
            fatal_in   = 1'b1;
            res_valid  = 1'b1;
            res_status = ST_FATAL_OVERLONG;
            res_abort  = 1'b1;
         end else begin
            pos_in = pos_ff + PW'(1);
            if (outcome_ff != 4'd0) begin
               // line already decided
            end else if (!head_item.is_hex) begin
               if (fail_s == ST_FATAL_DIGIT) begin
                  fatal_in   = 1'b1;
                  res_valid  = 1'b1;
                  res_status = ST_FATAL_DIGIT;
                  res_abort  = 1'b1;
               end else begin
                  outcome_in = fail_s + 4'd1;
               end
            end else if (pos_ff[0]) begin
               nib_in = head_item.nibble;
            end else begin
               sum_in = sum_next;
               if (byte_idx == '0) begin
                  len_in = byte_val;
               end else if (byte_idx == KW'(3)) begin
                  type_in = byte_val;
                  if (byte_val != 8'd0) begin
                     outcome_in = ST_OTHER_TYPE + 4'd1;
                  end else if (len_ff == 8'd0) begin
                     outcome_in = ST_ZERO_LEN + 4'd1;
                  end
               end else if (byte_idx >= KW'(4)) begin
                  if (byte_idx < data_lim) begin
                     crc_in = crc32_byte(crc_ff, byte_val);
                  end else begin
                     outcome_in = (sum_next == 8'd0) ? ST_OK + 4'd1 : ST_BAD_SUM + 4'd1;
                  end
               end
            end
         end
      end
   end

   // output handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         lines_ff     <= 32'd0;
         crc_ff       <= CRC_PRESET;
         len_ff       <= 8'd0;
         type_ff      <= 8'd0;
         sum_ff       <= 8'd0;
         nib_ff       <= 4'd0;
         outcome_ff   <= 4'd0;
         fatal_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         lines_ff     <= lines_in;
         crc_ff       <= crc_in;
         len_ff       <= len_in;
         type_ff      <= type_in;
         sum_ff       <= sum_in;
         nib_ff       <= nib_in;
         outcome_ff   <= outcome_in;
         fatal_ff     <= fatal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (res_valid) begin
         kind_ff   <= res_kind;
         status_ff <= res_status;
         number_ff <= res_number;
         rtype_ff  <= res_rtype;
         rcrc_ff   <= res_crc;
         abort_ff  <= res_abort;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_line_status = status_ff;
   assign rsp_line_number = number_ff;
   assign rsp_record_type = rtype_ff;
   assign rsp_crc_value   = rcrc_ff;
   assign rsp_aborted     = abort_ff;

endmodule

>>> hw/rtl/intel_hex_data_crc32_unit.sv
// top level of the hex record parser with crc-32 over data bytes
// path: an accepted word is registered in the front stage, queued, and its result registered
// throughput: one character word per cycle while the queue is not full and the output does not stall
// end of input with an open line gives two back-end reports: the line report, then the final one
// reset: synchronous active high, clears the parser to line start with crc preset to all ones
module intel_hex_data_crc32_unit import ihcrc_pkg::*; #(
   parameter int MAX_LINE = 1023
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [3:0]  rsp_line_status,
   output logic [31:0] rsp_line_number,
   output logic [7:0]  rsp_record_type,
   output logic [31:0] rsp_crc_value,
   output logic        rsp_aborted
);

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_empty;
   item_type push_item;
   item_type head_item;

   // character classification
   ihcrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_char_in (req_char_in),
      .push        (push),
      .push_item   (push_item),
      .queue_full  (queue_full)
   );

   // decoupling queue
   ihcrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // parser, crc and result register
   ihcrc_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_item       (head_item),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_line_status (rsp_line_status),
      .rsp_line_number (rsp_line_number),
      .rsp_record_type (rsp_record_type),
      .rsp_crc_value   (rsp_crc_value),
      .rsp_aborted     (rsp_aborted)
   );

endmodule

>>> hw/rtl/ihcrc_checker.sv
// port-level checks on the result channel, bound to the top level
module ihcrc_checker import ihcrc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [3:0]  rsp_line_status,
   input logic [31:0] rsp_line_number,
   input logic [7:0]  rsp_record_type,
   input logic [31:0] rsp_crc_value,
   input logic        rsp_aborted
);

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_line_status) && $stable(rsp_line_number)
         && $stable(rsp_crc_value) && $stable(rsp_aborted))
      else $error("result word changed while stalled");

   // final report carries no line status or record type
   a_final_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_FINAL |->
         rsp_line_status == ST_OK && rsp_record_type == 8'd0)
      else $error("final report with line fields set");

   // an aborting line report is one of the fatal codes
   a_abort_fatal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_LINE && rsp_aborted |->
         rsp_line_status == ST_FATAL_DIGIT || rsp_line_status == ST_FATAL_OVERLONG)
      else $error("abort flag on a non-fatal line");

   // a fatal code always raises the abort flag
   a_fatal_abort: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_LINE &&
         (rsp_line_status == ST_FATAL_DIGIT || rsp_line_status == ST_FATAL_OVERLONG)
         |-> rsp_aborted)
      else $error("fatal line without abort flag");

   // line status stays in the defined code range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_status <= ST_FATAL_OVERLONG)
      else $error("line status out of range");

endmodule

bind intel_hex_data_crc32_unit ihcrc_checker u_ihcrc_checker (.*);
